### hw/rtl/spq_pkg.sv
package spq_pkg;

    // command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_TOP  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // order modes, new priority versus stored priority
    localparam logic [1:0] MODE_LT = 2'd0;
    localparam logic [1:0] MODE_LE = 2'd1;
    localparam logic [1:0] MODE_GT = 2'd2;
    localparam logic [1:0] MODE_GE = 2'd3;

    // register map
    localparam logic REG_ORDER_MODE = 1'b0;

    // command beat
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_cmd_beat;

    // result beat
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] front_priority;
        logic               is_empty;
    } t_result_beat;

    // control shared by every cell of the chain
    typedef struct packed {
        logic push_cmp;
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

### hw/rtl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of cells, front entry in cell 0.
// Command channel: i_cmd is taken at an edge where start is high and busy is
// low; cmd selects push, pop or top (code 3 does nothing and reports ok).
// Result channel: o_result is valid for exactly one cycle while o_done is
// high; the receiver always takes it, there is no back-pressure.
// Pop, top, error cases and no-ops: result registered at the accepting
// edge, busy stays low, so one such command per cycle is sustained.
// Push with room: the accepting edge registers each cell's compare of the
// new priority; the insertion edge resolves the first hit along the cell
// chain and shifts/inserts. busy is high from the accepting edge until the
// insertion edge, and the result is registered at the insertion edge.
// Push when full drops the pair and reports status full; pop or top when
// empty reports status empty. Both leave the queue unchanged.
// Configuration: order_mode at byte address 0 over the APB port, writes take
// effect at the access edge; write only while no command is in flight.
// Reset (i_rst_n low, synchronous) empties the queue, sets order_mode to
// less-or-equal and clears o_done and busy.
module sorted_priority_queue_unit #(
    parameter int DEPTH          = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  spq_pkg::t_cmd_beat    i_cmd,
    output logic                  o_done,
    output spq_pkg::t_result_beat o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_INSERT = 1'b1;

    logic                      r_state;
    logic                      n_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [1:0]                r_mode;
    logic                      r_done;
    logic                      n_done;
    spq_pkg::t_result_beat     r_result;
    spq_pkg::t_result_beat     n_result;
    logic [VALUE_WIDTH-1:0]    r_new_value;
    logic [PRIORITY_WIDTH-1:0] r_new_prio;
    logic [VALUE_WIDTH-1:0]    w_in_value;
    logic [PRIORITY_WIDTH-1:0] w_in_prio;
    spq_pkg::t_cell_ctl        w_ctl;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic [63:0]               w_front_value;
    logic [63:0]               w_front_prio;

    logic [VALUE_WIDTH-1:0]    w_value [DEPTH];
    logic [PRIORITY_WIDTH-1:0] w_prio  [DEPTH];
    logic                      w_found [DEPTH+1];

    assign busy     = (r_state == ST_INSERT);
    assign w_accept = start & ~busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    // incoming pair kept to the storage widths
    assign w_in_value = VALUE_WIDTH'(64'({32'd0, i_cmd.item_value}));
    assign w_in_prio  = PRIORITY_WIDTH'(64'({32'd0, i_cmd.item_priority}));

    // front entry sign-extended for the result beat
    assign w_front_value = 64'($signed(w_value[0]));
    assign w_front_prio  = 64'($signed(w_prio[0]));

    // command decode and result build
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_result = '0;
        w_ctl    = '0;
        n_result.is_empty = w_empty;
        if (r_state == ST_INSERT) begin
            w_ctl.insert      = 1'b1;
            n_count           = r_count + CW'(1);
            n_state           = ST_IDLE;
            n_done            = 1'b1;
            n_result.status   = spq_pkg::STATUS_OK;
            n_result.is_empty = 1'b0;
        end else if (w_accept) begin
            n_done = 1'b1;
            unique case (i_cmd.cmd) inside
                spq_pkg::CMD_PUSH: begin
                    if (w_full) begin
                        n_result.status = spq_pkg::STATUS_FULL;
                    end else begin
                        w_ctl.push_cmp = 1'b1;
                        n_state        = ST_INSERT;
                        n_done         = 1'b0;
                    end
                end
                spq_pkg::CMD_POP, spq_pkg::CMD_TOP: begin
                    if (w_empty) begin
                        n_result.status = spq_pkg::STATUS_EMPTY;
                    end else begin
                        n_result.front_value    = w_front_value[31:0];
                        n_result.front_priority = w_front_prio[31:0];
                        if (i_cmd.cmd == spq_pkg::CMD_POP) begin
                            w_ctl.pop         = 1'b1;
                            n_count           = r_count - CW'(1);
                            n_result.is_empty = (r_count == CW'(1));
                        end
                    end
                end
                default: begin
                    n_result.status = spq_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // result beat and pending push pair
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (w_ctl.push_cmp) begin
            r_new_value <= w_in_value;
            r_new_prio  <= w_in_prio;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= spq_pkg::MODE_LE;
        end else if (psel && penable && pwrite && paddr[2] == spq_pkg::REG_ORDER_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == spq_pkg::REG_ORDER_MODE) begin
            prdata = {30'd0, r_mode};
        end
    end

    assign pready = 1'b1;

    // chain of cells, first hit ripples toward the tail
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0]    w_lv;
        logic [PRIORITY_WIDTH-1:0] w_lp;
        logic [VALUE_WIDTH-1:0]    w_rv;
        logic [PRIORITY_WIDTH-1:0] w_rp;

        if (g == 0) begin : g_head
            assign w_lv = r_new_value;
            assign w_lp = r_new_prio;
        end else begin : g_body
            assign w_lv = w_value[g-1];
            assign w_lp = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rv = w_value[g];
            assign w_rp = w_prio[g];
        end else begin : g_inner
            assign w_rv = w_value[g+1];
            assign w_rp = w_prio[g+1];
        end

        spq_cell #(
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_order_mode  (r_mode),
            .i_occupied    (CW'(g) < r_count),
            .i_cmp_prio    (w_in_prio),
            .i_new_value   (r_new_value),
            .i_new_prio    (r_new_prio),
            .i_left_value  (w_lv),
            .i_left_prio   (w_lp),
            .i_right_value (w_rv),
            .i_right_prio  (w_rp),
            .i_found       (w_found[g]),
            .o_value       (w_value[g]),
            .o_prio        (w_prio[g]),
            .o_found       (w_found[g+1])
        );
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hw/rtl/spq_cell.sv
module spq_cell #(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 32
) (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctl        i_ctl,
    input  logic [1:0]                i_order_mode,
    input  logic                      i_occupied,
    input  logic [PRIORITY_WIDTH-1:0] i_cmp_prio,
    input  logic [VALUE_WIDTH-1:0]    i_new_value,
    input  logic [PRIORITY_WIDTH-1:0] i_new_prio,
    input  logic [VALUE_WIDTH-1:0]    i_left_value,
    input  logic [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic [VALUE_WIDTH-1:0]    i_right_value,
    input  logic [PRIORITY_WIDTH-1:0] i_right_prio,
    input  logic                      i_found,
    output logic [VALUE_WIDTH-1:0]    o_value,
    output logic [PRIORITY_WIDTH-1:0] o_prio,
    output logic                      o_found
);

    logic [VALUE_WIDTH-1:0]    r_value;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic                      r_hit;
    logic                      w_lt;
    logic                      w_eq;
    logic                      w_rel;

    // relation of the incoming priority against the stored one
    assign w_lt = $signed(i_cmp_prio) < $signed(r_prio);
    assign w_eq = i_cmp_prio == r_prio;

    always_comb begin
        case (i_order_mode)
            spq_pkg::MODE_LT: w_rel = w_lt;
            spq_pkg::MODE_LE: w_rel = w_lt | w_eq;
            spq_pkg::MODE_GT: w_rel = ~(w_lt | w_eq);
            default:          w_rel = ~w_lt;
        endcase
    end

    // hit flag, then insert or shift on the following edge
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_cmp) begin
            r_hit <= ~i_occupied | w_rel;
        end
        if (i_ctl.insert) begin
            if (i_found) begin
                r_value <= i_left_value;
                r_prio  <= i_left_prio;
            end else if (r_hit) begin
                r_value <= i_new_value;
                r_prio  <= i_new_prio;
            end
        end else if (i_ctl.pop) begin
            r_value <= i_right_value;
            r_prio  <= i_right_prio;
        end
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;
    assign o_found = i_found | r_hit;

endmodule
